// ===== rtl/rpbc_pkg.sv =====
// shared types and constants of the rotate, project and back-face cull block
package rpbc_pkg;

   // fixed-point layout
   localparam int FRAC_BITS   = 14;
   localparam int CENTRE_X    = 128;
   localparam int CENTRE_Y    = 96;
   localparam int SCREEN_DIST = 512;
   localparam int EYE_DIST    = 256;
   localparam int SCR_W       = 13;
   localparam int QMAG_W      = 14;
   localparam int NUM_W       = 40;
   localparam int DEN_W       = 28;

   // register indexes
   localparam logic [2:0] CSR_COS_X = 3'd0;
   localparam logic [2:0] CSR_SIN_X = 3'd1;
   localparam logic [2:0] CSR_COS_Y = 3'd2;
   localparam logic [2:0] CSR_SIN_Y = 3'd3;
   localparam logic [2:0] CSR_COS_Z = 3'd4;
   localparam logic [2:0] CSR_SIN_Z = 3'd5;
   localparam logic [2:0] CSR_FILL  = 3'd6;

   // operation codes
   localparam logic OP_VERTEX = 1'b0;
   localparam logic OP_FACE   = 1'b1;

   // one projected vertex
   typedef struct packed {
      logic signed [SCR_W-1:0] x;
      logic signed [SCR_W-1:0] y;
   } vertex_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROT,
      ST_DIVX,
      ST_DIVY,
      ST_READ,
      ST_AREA
   } state_type;

endpackage

// ===== rtl/rotate_project_backface_cull.sv =====
// top level: rotation and projection sequencer, vertex store and face test
//
// channel   direction  handshake                 word
// req_*     in         start high, busy low      vertex or face command
// rsp_*     out        rsp_strobe, one cycle     face corners, colour, flags
// csr_*     in         csr_write_enable          one rotation or fill register
//
// a vertex runs its rotation steps on the shared multiplier, then two
// divisions; a face reads its corners from the vertex store, then runs
// three area steps on the same multiplier
// the result strobe is registered from the last area step
// reset clears the sequencer and loads the identity rotation; the vertex
// store holds no reset value
// the receiver cannot stall, so results never wait
module rotate_project_backface_cull #(
   parameter int VERTEX_SLOTS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_operation,
   input  logic [2:0]                         req_vertex_index,
   input  logic signed [7:0]                  req_point_x,
   input  logic signed [7:0]                  req_point_y,
   input  logic signed [7:0]                  req_point_z,
   input  logic [2:0]                         req_corner_one,
   input  logic [2:0]                         req_corner_two,
   input  logic [2:0]                         req_corner_three,
   input  logic [2:0]                         req_corner_four,
   input  logic [7:0]                         req_face_colour,
   output logic                               rsp_strobe,
   output logic                               rsp_visible,
   output logic signed [rpbc_pkg::SCR_W-1:0]  rsp_screen_x1,
   output logic signed [rpbc_pkg::SCR_W-1:0]  rsp_screen_y1,
   output logic signed [rpbc_pkg::SCR_W-1:0]  rsp_screen_x2,
   output logic signed [rpbc_pkg::SCR_W-1:0]  rsp_screen_y2,
   output logic signed [rpbc_pkg::SCR_W-1:0]  rsp_screen_x3,
   output logic signed [rpbc_pkg::SCR_W-1:0]  rsp_screen_y3,
   output logic signed [rpbc_pkg::SCR_W-1:0]  rsp_screen_x4,
   output logic signed [rpbc_pkg::SCR_W-1:0]  rsp_screen_y4,
   output logic [7:0]                         rsp_out_colour,
   output logic                               rsp_fill,
   input  logic                               csr_write_enable,
   input  logic [2:0]                         csr_index,
   input  logic [15:0]                        csr_write_data
);
   import rpbc_pkg::*;

   localparam int AW = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;
   localparam int IW = (AW > 3) ? AW : 3;
   localparam logic signed [DEN_W-1:0] EYE_Q = DEN_W'(EYE_DIST << FRAC_BITS);

   state_type state_ff, state_in;
   logic [3:0] step_ff, step_in;

   // configuration
   logic signed [15:0] cfg_ff [6];
   logic               fill_ff;

   // captured command
   logic [2:0]         slot_ff;
   logic signed [7:0]  px_ff, py_ff, pz_ff;
   logic [2:0]         corner_ff [4];
   logic [7:0]         colour_ff;

   // rotation datapath
   logic signed [45:0] acc_ff, acc_in;
   logic signed [25:0] y1_ff, z1_ff;
   logic signed [26:0] x2_ff, z2_ff;
   logic signed [28:0] x3_ff, y3_ff;
   logic signed [SCR_W-1:0] sx_ff;
   logic signed [27:0] mul_a;
   logic signed [15:0] mul_b;
   logic signed [43:0] prod;

   // face datapath
   logic signed [SCR_W-1:0] cx_ff [4];
   logic signed [SCR_W-1:0] cy_ff [4];
   logic                    oor_ff;
   logic                    visible_ff, rsp_fill_ff, strobe_ff;
   logic signed [45:0]      area;

   // divider and store links
   logic                    div_start, div_done;
   logic signed [NUM_W-1:0] div_num;
   logic signed [DEN_W-1:0] d_val;
   logic signed [SCR_W-1:0] div_quo;
   logic                    wr_en, rd_en, rd_ok;
   logic [IW-1:0]           wr_idx, rd_idx;
   logic [2:0]              rd_slot;
   logic [1:0]              cap_idx;
   vertex_type              wr_data, rd_data;

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = 4'd0;
            if (start) begin
               state_in = (req_operation == OP_FACE) ? ST_READ : ST_ROT;
            end
         end
         ST_ROT: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd11) begin
               state_in = ST_DIVX;
               step_in  = 4'd0;
            end
         end
         ST_DIVX: begin
            step_in = 4'd1;
            if (div_done) begin
               state_in = ST_DIVY;
               step_in  = 4'd0;
            end
         end
         ST_DIVY: begin
            step_in = 4'd1;
            if (div_done) begin
               state_in = ST_IDLE;
               step_in  = 4'd0;
            end
         end
         ST_READ: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd4) begin
               state_in = ST_AREA;
               step_in  = 4'd0;
            end
         end
         ST_AREA: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd2) begin
               state_in = ST_IDLE;
               step_in  = 4'd0;
            end
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = 4'd0;
         end
      endcase
   end

   // shared multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_ROT: begin
            unique case (step_ff)
               4'd0:    begin mul_a = 28'(py_ff); mul_b = cfg_ff[CSR_COS_X]; end
               4'd1:    begin mul_a = 28'(pz_ff); mul_b = cfg_ff[CSR_SIN_X]; end
               4'd2:    begin mul_a = 28'(py_ff); mul_b = cfg_ff[CSR_SIN_X]; end
               4'd3:    begin mul_a = 28'(pz_ff); mul_b = cfg_ff[CSR_COS_X]; end
               4'd4:    begin mul_a = 28'(px_ff); mul_b = cfg_ff[CSR_COS_Y]; end
               4'd5:    begin mul_a = 28'(z1_ff); mul_b = cfg_ff[CSR_SIN_Y]; end
               4'd6:    begin mul_a = 28'(px_ff); mul_b = cfg_ff[CSR_SIN_Y]; end
               4'd7:    begin mul_a = 28'(z1_ff); mul_b = cfg_ff[CSR_COS_Y]; end
               4'd8:    begin mul_a = 28'(x2_ff); mul_b = cfg_ff[CSR_COS_Z]; end
               4'd9:    begin mul_a = 28'(y1_ff); mul_b = cfg_ff[CSR_SIN_Z]; end
               4'd10:   begin mul_a = 28'(x2_ff); mul_b = cfg_ff[CSR_SIN_Z]; end
               4'd11:   begin mul_a = 28'(y1_ff); mul_b = cfg_ff[CSR_COS_Z]; end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         ST_AREA: begin
            unique case (step_ff)
               4'd0:    begin mul_a = 28'(cx_ff[0]); mul_b = 16'(cy_ff[1] - cy_ff[2]); end
               4'd1:    begin mul_a = 28'(cx_ff[1]); mul_b = 16'(cy_ff[2] - cy_ff[0]); end
               4'd2:    begin mul_a = 28'(cx_ff[2]); mul_b = 16'(cy_ff[0] - cy_ff[1]); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod   = mul_a * mul_b;
      // each rotation pair starts on an even step, the area sum on step zero
      acc_in = ((state_ff == ST_ROT) ? !step_ff[0] : (step_ff == 4'd0)) ?
               46'(prod) : acc_ff + 46'(prod);
      area   = acc_ff + 46'(prod);
   end

   // projection numerators, divider and store controls
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      d_val     = EYE_Q - 28'(z2_ff);
      div_start = ((state_ff == ST_DIVX) || (state_ff == ST_DIVY)) && (step_ff == 4'd0);
      if (state_ff == ST_DIVX) begin
         div_num = 40'(d_val) * 40'(CENTRE_X) + 40'(x3_ff) * 40'(SCREEN_DIST);
      end else begin
         div_num = 40'(d_val) * 40'(CENTRE_Y) + 40'(y3_ff) * 40'(SCREEN_DIST);
      end
      wr_idx    = IW'(slot_ff);
      wr_en     = (state_ff == ST_DIVY) && div_done && ({29'd0, slot_ff} < VERTEX_SLOTS);
      wr_data.x = sx_ff;
      wr_data.y = div_quo;
      rd_slot   = corner_ff[step_ff[1:0]];
      rd_idx    = IW'(rd_slot);
      rd_ok     = ({29'd0, rd_slot} < VERTEX_SLOTS);
      rd_en     = (state_ff == ST_READ) && (step_ff < 4'd4);
      cap_idx   = 2'(step_ff - 4'd1);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         step_ff   <= 4'd0;
         strobe_ff <= 1'b0;
         cfg_ff[CSR_COS_X] <= 16'sd16384;
         cfg_ff[CSR_SIN_X] <= 16'sd0;
         cfg_ff[CSR_COS_Y] <= 16'sd16384;
         cfg_ff[CSR_SIN_Y] <= 16'sd0;
         cfg_ff[CSR_COS_Z] <= 16'sd16384;
         cfg_ff[CSR_SIN_Z] <= 16'sd0;
         fill_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         strobe_ff <= (state_ff == ST_AREA) && (step_ff == 4'd2);
         // register writes
         if (csr_write_enable) begin
            priority if (csr_index < CSR_FILL) begin
               cfg_ff[csr_index] <= csr_write_data;
            end else if (csr_index == CSR_FILL) begin
               fill_ff <= csr_write_data[0];
            end
         end
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      // capture command word
      if (start && !busy) begin
         slot_ff   <= req_vertex_index;
         px_ff     <= req_point_x;
         py_ff     <= req_point_y;
         pz_ff     <= req_point_z;
         corner_ff[0] <= req_corner_one;
         corner_ff[1] <= req_corner_two;
         corner_ff[2] <= req_corner_three;
         corner_ff[3] <= req_corner_four;
         colour_ff <= req_face_colour;
      end
      // rotation steps
      if (state_ff == ST_ROT) begin
         unique case (step_ff)
            4'd1:    y1_ff <= 26'(acc_ff - 46'(prod));
            4'd3:    z1_ff <= 26'(acc_ff + 46'(prod));
            4'd5:    x2_ff <= 27'(acc_ff - 46'(prod >>> FRAC_BITS));
            4'd7:    z2_ff <= 27'(acc_ff + 46'(prod >>> FRAC_BITS));
            4'd9:    x3_ff <= 29'((acc_ff - 46'(prod)) >>> FRAC_BITS);
            4'd11:   y3_ff <= 29'((acc_ff + 46'(prod)) >>> FRAC_BITS);
            default: acc_ff <= acc_in;
         endcase
      end
      // screen x waits for screen y
      if ((state_ff == ST_DIVX) && div_done) begin
         sx_ff <= div_quo;
      end
      // corner reads, captured in the cycle after the address
      if (rd_en) begin
         oor_ff <= !rd_ok;
      end
      if ((state_ff == ST_READ) && (step_ff != 4'd0)) begin
         cx_ff[cap_idx] <= oor_ff ? '0 : rd_data.x;
         cy_ff[cap_idx] <= oor_ff ? '0 : rd_data.y;
      end
      // signed area
      if (state_ff == ST_AREA) begin
         acc_ff <= acc_in;
         if (step_ff == 4'd2) begin
            visible_ff  <= (area <= 46'sd0);
            rsp_fill_ff <= fill_ff;
         end
      end
   end

   rpbc_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .div_num   (div_num),
      .div_den   (d_val),
      .div_done  (div_done),
      .div_quo   (div_quo)
   );

   rpbc_vstore #(
      .SLOTS (VERTEX_SLOTS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx[AW-1:0]),
      .rd_data (rd_data)
   );

   assign rsp_strobe     = strobe_ff;
   assign rsp_visible    = visible_ff;
   assign rsp_screen_x1  = cx_ff[0];
   assign rsp_screen_y1  = cy_ff[0];
   assign rsp_screen_x2  = cx_ff[1];
   assign rsp_screen_y2  = cy_ff[1];
   assign rsp_screen_x3  = cx_ff[2];
   assign rsp_screen_y3  = cy_ff[2];
   assign rsp_screen_x4  = cx_ff[3];
   assign rsp_screen_y4  = cy_ff[3];
   assign rsp_out_colour = colour_ff;
   assign rsp_fill       = rsp_fill_ff;

`ifndef SYNTHESIS
   // a result only follows the last area step
   a_strobe_after_area: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_AREA))
      else $error("result strobe without area step");

   // the store is written only when the second division ends
   a_write_in_divy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_DIVY) && div_done)
      else $error("vertex store written outside projection");

   // the divider answers only while a vertex is projected
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> ((state_ff == ST_DIVX) || (state_ff == ST_DIVY)))
      else $error("divider done outside projection");

   // busy is raised after every command that is taken
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after a command");
`endif

endmodule

// ===== rtl/rpbc_divider.sv =====
// iterative signed divider with 13-bit saturated quotient, truncating toward zero
module rpbc_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             div_start,
   input  logic signed [rpbc_pkg::NUM_W-1:0] div_num,
   input  logic signed [rpbc_pkg::DEN_W-1:0] div_den,
   output logic                             div_done,
   output logic signed [rpbc_pkg::SCR_W-1:0] div_quo
);
   import rpbc_pkg::*;

   localparam int RW = DEN_W + QMAG_W;

   logic              busy_ff;
   logic [3:0]        cnt_ff;
   logic [RW-1:0]     rem_ff;
   logic [RW-1:0]     dsh_ff;
   logic [QMAG_W-1:0] q_ff;
   logic              neg_ff;
   logic              done_ff;
   logic signed [SCR_W-1:0] quo_ff;

   logic [NUM_W-1:0]  nmag;
   logic [DEN_W-1:0]  dmag;
   logic              neg;
   logic              fits;
   logic              take;
   logic [QMAG_W-1:0] q_in;

   // clamp a quotient magnitude to the screen range
   function automatic logic signed [SCR_W-1:0] clamp_q(input logic n,
                                                       input logic [QMAG_W-1:0] m);
      logic signed [QMAG_W:0] neg_m;
      neg_m = -$signed({1'b0, m});
      if (!n) begin
         clamp_q = (m > QMAG_W'(4095)) ? SCR_W'(4095) : SCR_W'(m);
      end else begin
         clamp_q = (m > QMAG_W'(4096)) ? SCR_W'(-4096) : SCR_W'(neg_m);
      end
   endfunction

   // magnitudes and early saturation test
   always_comb begin
      nmag = div_num[NUM_W-1] ? NUM_W'(-div_num) : NUM_W'(div_num);
      dmag = div_den[DEN_W-1] ? DEN_W'(-div_den) : DEN_W'(div_den);
      neg  = div_num[NUM_W-1] ^ div_den[DEN_W-1];
      fits = RW'(nmag) < {dmag, {QMAG_W{1'b0}}};
      take = rem_ff >= dsh_ff;
      q_in = {q_ff[QMAG_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_start) begin
            neg_ff <= neg;
            if (div_num == '0) begin
               quo_ff  <= '0;
               done_ff <= 1'b1;
            end else if (!fits) begin
               quo_ff  <= clamp_q(neg, {QMAG_W{1'b1}});
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
               cnt_ff  <= 4'(QMAG_W - 1);
               rem_ff  <= RW'(nmag);
               dsh_ff  <= RW'({dmag, {(QMAG_W-1){1'b0}}});
               q_ff    <= '0;
            end
         end else if (busy_ff) begin
            // one quotient bit a cycle
            if (take) begin
               rem_ff <= rem_ff - dsh_ff;
            end
            dsh_ff <= dsh_ff >> 1;
            q_ff   <= q_in;
            cnt_ff <= cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               quo_ff  <= clamp_q(neg_ff, q_in);
            end
         end
      end
   end

   assign div_done = done_ff;
   assign div_quo  = quo_ff;

endmodule

// ===== rtl/rpbc_vstore.sv =====
// projected vertex memory, one write port and one registered read port
module rpbc_vstore #(
   parameter int SLOTS = 8,
   parameter int AW    = 3
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  rpbc_pkg::vertex_type   wr_data,
   input  logic                   rd_en,
   input  logic [AW-1:0]          rd_addr,
   output rpbc_pkg::vertex_type   rd_data
);
   import rpbc_pkg::*;

   vertex_type mem [SLOTS];
   vertex_type rd_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule
